// ----- hdl/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// Request and status codes and helpers for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int MAP_WORD_BITS = 64;
    localparam int INDEX_SPACE   = 4096;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_MARK  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef logic [MAP_WORD_BITS-1:0] t_map_word;

    // Position of the lowest set bit; zero when no bit is set.
    function automatic logic [5:0] lowest_set(input t_map_word v);
        logic [5:0] pos;
        pos = 6'd0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = 6'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ----- hdl/bitmap_page_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page frame allocator over a one-bit-per-page used map.
// ----------------------------------------------------------------------------
// Requests enter on i_start while o_busy is low: i_req_type selects allocate,
// free or mark-used, i_page_index names the page for the latter two. Every
// request yields one result on o_granted_page/o_status, valid for the single
// cycle o_strobe is high; the receiver cannot stall it.
// Unknown kinds, out-of-range indices and allocation with a zero page count
// answer in the cycle after acceptance. Free and mark-used read, then write
// back one map word. Allocation reads one 64-bit map word per cycle from the
// lowest page up until it finds a free page or has examined ceil(page count /
// 64) words; the single map RAM read port is why it reads one word at a time.
// o_busy stays high until the result is strobed; a new request may be taken
// in the strobe cycle.
// The page count register is written through i_cfg_valid/o_cfg_ready and
// saturates to NUM_PAGES and 4096. Reset sets it to 4096 and marks every page
// used at once through per-word valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_req_type,
    input  logic [11:0] i_page_index,
    output logic        o_strobe,
    output logic [11:0] o_granted_page,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data
);

    localparam int LIMIT_MAX_I = (NUM_PAGES < INDEX_SPACE) ? NUM_PAGES : INDEX_SPACE;
    localparam logic [12:0] LIMIT_MAX = 13'(LIMIT_MAX_I);
    localparam int WORDS = (LIMIT_MAX_I + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RMW  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [12:0]      r_pages;
    logic [WORDS-1:0] r_vld;
    logic [1:0]       r_kind, n_kind;
    logic [11:0]      r_idx, n_idx;
    logic [12:0]      r_limit, n_limit;
    logic [6:0]       r_word, n_word;
    logic             r_strobe, n_strobe;
    logic [11:0]      r_granted, n_granted;
    logic [1:0]       r_status, n_status;

    logic             accept;
    logic [12:0]      lim;
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_wa, ram_ra;
    t_map_word        ram_wd, ram_rd;
    t_map_word        cur_word, valid_mask, free_bits, bit_mask;
    logic [12:0]      span, next_base;
    logic [6:0]       word_inc;
    logic [5:0]       free_pos;

    bpa_ram #(
        .WIDTH(MAP_WORD_BITS),
        .DEPTH(WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_re    (ram_re),
        .i_raddr (ram_ra),
        .o_rdata (ram_rd)
    );

    assign accept = i_start && (r_state == S_IDLE);
    assign lim    = (r_pages > LIMIT_MAX) ? LIMIT_MAX : r_pages;

    // A word never written still holds its reset value: every page used.
    assign cur_word  = r_vld[r_word[AW-1:0]] ? ram_rd : '1;
    assign span      = r_limit - {r_word[6:0], 6'b0};
    assign valid_mask = (span >= 13'd64) ? '1
                      : ((t_map_word'(1) << span[5:0]) - t_map_word'(1));
    assign free_bits = ~cur_word & valid_mask;
    assign free_pos  = lowest_set(free_bits);
    assign word_inc  = r_word + 7'd1;
    assign next_base = {word_inc, 6'b0};
    assign bit_mask  = t_map_word'(1) << ((r_state == S_SCAN) ? free_pos : r_idx[5:0]);

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_idx     = r_idx;
        n_limit   = r_limit;
        n_word    = r_word;
        n_strobe  = 1'b0;
        n_granted = r_granted;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_wa    = r_word[AW-1:0];
        ram_wd    = cur_word;
        ram_re    = 1'b0;
        ram_ra    = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind    = i_req_type;
                    n_idx     = i_page_index;
                    n_limit   = lim;
                    n_granted = '0;
                    n_status  = ST_OK;
                    case (i_req_type)
                        REQ_ALLOC: begin
                            if (lim == 13'd0) begin
                                n_strobe = 1'b1;
                                n_status = ST_OOM;
                            end else begin
                                n_word  = '0;
                                ram_re  = 1'b1;
                                ram_ra  = '0;
                                n_state = S_SCAN;
                            end
                        end
                        REQ_FREE, REQ_MARK: begin
                            if ({1'b0, i_page_index} >= lim) begin
                                n_strobe = 1'b1;
                                n_status = ST_RANGE;
                            end else begin
                                n_word  = {1'b0, i_page_index[11:6]};
                                ram_re  = 1'b1;
                                ram_ra  = AW'(i_page_index >> 6);
                                n_state = S_RMW;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (free_bits != '0) begin
                    ram_we    = 1'b1;
                    ram_wd    = cur_word | bit_mask;
                    n_strobe  = 1'b1;
                    n_granted = {r_word[5:0], free_pos};
                    n_status  = ST_OK;
                    n_state   = S_IDLE;
                end else if (next_base >= r_limit) begin
                    n_strobe = 1'b1;
                    n_status = ST_OOM;
                    n_state  = S_IDLE;
                end else begin
                    // advance to the next map word
                    n_word = word_inc;
                    ram_re = 1'b1;
                    ram_ra = word_inc[AW-1:0];
                end
            end
            S_RMW: begin
                ram_we   = 1'b1;
                ram_wd   = (r_kind == REQ_MARK) ? (cur_word | bit_mask)
                                                : (cur_word & ~bit_mask);
                n_strobe = 1'b1;
                n_status = ST_OK;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_pages  <= 13'd4096;
            r_vld    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pages <= i_cfg_data;
            end
            if (ram_we) begin
                r_vld[ram_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_idx     <= n_idx;
        r_limit   <= n_limit;
        r_word    <= n_word;
        r_granted <= n_granted;
        r_status  <= n_status;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_cfg_ready    = (r_state == S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_granted_page = r_granted;
    assign o_status       = r_status;

    // Results with an error status carry page zero.
    a_err_zero_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_granted_page == 12'd0))
        else $error("error result with nonzero page");

    // A granted page lies below the page count captured with the request.
    a_grant_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_kind == REQ_ALLOC && o_status == ST_OK)
            |-> ({1'b0, o_granted_page} < r_limit))
        else $error("granted page beyond page count");

    // The map is only written while a request is in progress.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state != S_IDLE))
        else $error("map write while idle");

    // The block goes busy only on an accepted request.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(accept))
        else $error("busy without request");

    // Leaving a working state always delivers a result.
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && n_state == S_IDLE) |=> o_strobe)
        else $error("request finished without result");

endmodule

// ----- hdl/bpa_ram.sv -----
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- bench/bitmap_page_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_allocator_tb
// Self-checking bench for the first-fit bitmap page allocator.
// ----------------------------------------------------------------------------
// A behavioral copy of the used map and the page count register predicts the
// result of every accepted request. A monitor compares each strobed result,
// field by field, against the oldest prediction. Directed requests cover the
// corners of the map and of the page count. Random phases then sweep the page
// count, mix allocate, free, mark-used and unknown requests, and vary the gaps
// between requests.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_tb
    import bpa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CLK_PERIOD  = 10;
    localparam int         PAGE_SLOTS  = 4096;
    localparam int         TAIL_CYCLES = 80;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [11:0] page;
        logic [1:0]  status;
    } t_page_reply;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_start      = 1'b0;
    logic [1:0]  i_req_type   = '0;
    logic [11:0] i_page_index = '0;
    logic        i_cfg_valid  = 1'b0;
    logic [12:0] i_cfg_data   = '0;
    logic        o_busy;
    logic        o_strobe;
    logic [11:0] o_granted_page;
    logic [1:0]  o_status;
    logic        o_cfg_ready;

    // Mirror of the block's state
    bit          page_used [PAGE_SLOTS];
    logic [12:0] page_count;
    t_page_reply pending_replies[$];

    int error_count    = 0;
    int request_count  = 0;
    int reply_count    = 0;
    int grant_count    = 0;
    int oom_count      = 0;
    int range_count    = 0;
    int setting_count  = 0;
    int burst_left     = 0;
    bit gaps_enabled   = 1'b1;

    bitmap_page_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_req_type     (i_req_type),
        .i_page_index   (i_page_index),
        .o_strobe       (o_strobe),
        .o_granted_page (o_granted_page),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("Timeout at %0t", $time);
        $display("Test completed with failures");
        $finish;
    end

    function automatic int active_pages();
        return (page_count > PAGE_SLOTS) ? PAGE_SLOTS : int'(page_count);
    endfunction

    // Apply one request to the mirrored map and return the reply it earns.
    function automatic t_page_reply predict_reply(logic [1:0] kind, logic [11:0] idx);
        t_page_reply reply;
        int          lim;
        lim    = active_pages();
        reply  = '{page: '0, status: ST_OK};
        if (kind == REQ_ALLOC) begin
            reply.status = ST_OOM;
            for (int p = 0; p < lim; p++) begin
                if (!page_used[p]) begin
                    page_used[p] = 1'b1;
                    reply.page   = 12'(p);
                    reply.status = ST_OK;
                    break;
                end
            end
        end else if (kind == REQ_FREE || kind == REQ_MARK) begin
            if (int'(idx) >= lim) begin
                reply.status = ST_RANGE;
            end else begin
                page_used[idx] = (kind == REQ_MARK);
            end
        end
        return reply;
    endfunction

    // Check each strobed result against the oldest prediction
    always @(posedge i_clk) begin
        t_page_reply want;
        if (i_rst_n && o_strobe) begin
            reply_count++;
            if (pending_replies.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result page=%0d status=%0d", $time,
                         o_granted_page, o_status);
            end else begin
                want = pending_replies.pop_front();
                if (o_granted_page !== want.page) begin
                    error_count++;
                    $display("%0t: granted_page expected %0d actual %0d", $time,
                             want.page, o_granted_page);
                end
                if (o_status !== want.status) begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, o_status);
                end
                if (want.status == ST_OOM) oom_count++;
                else if (want.status == ST_RANGE) range_count++;
                else if (want.page != 0 || o_granted_page != 0) grant_count++;
            end
        end
    end

    // Present one request and hold it until the block takes it.
    task automatic send_request(logic [1:0] kind, logic [11:0] idx);
        t_page_reply reply;
        i_start      <= 1'b1;
        i_req_type   <= kind;
        i_page_index <= idx;
        do @(posedge i_clk); while (o_busy);
        reply = predict_reply(kind, idx);
        pending_replies.push_back(reply);
        request_count++;
    endtask

    // Advance the burst; at its end drop start for a random gap.
    task automatic pace_requests();
        int gap;
        if (!gaps_enabled) return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 15);
        gap        = $urandom_range(0, 6);
        if (gap > 0) begin
            i_start      <= 1'b0;
            i_req_type   <= 2'($urandom);
            i_page_index <= 12'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        while (pending_replies.size() > 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_page_count(logic [12:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        page_count   = value;
        setting_count++;
    endtask

    function automatic logic [11:0] pick_index();
        int lim;
        int roll;
        lim  = active_pages();
        roll = $urandom_range(0, 99);
        if (roll < 10 || lim == 0) return 12'($urandom_range(0, PAGE_SLOTS - 1));
        if (roll < 55) return 12'($urandom_range(0, ((lim < 128) ? lim : 128) - 1));
        return 12'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [1:0] pick_kind();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return REQ_ALLOC;
        if (roll < 75) return REQ_FREE;
        if (roll < 92) return REQ_MARK;
        return REQ_UNKNOWN;
    endfunction

    task automatic test_reset_and_corners();
        // Everything is used after reset
        send_request(REQ_ALLOC, 12'd0);
        send_request(REQ_FREE, 12'd0);
        send_request(REQ_FREE, 12'd4095);
        send_request(REQ_ALLOC, 12'hFFF);
        send_request(REQ_ALLOC, 12'd0);
        send_request(REQ_ALLOC, 12'd0);
        send_request(REQ_UNKNOWN, 12'hFFF);
        send_request(REQ_MARK, 12'd5);
        send_request(REQ_FREE, 12'd5);
        send_request(REQ_FREE, 12'd5);
        send_request(REQ_MARK, 12'd5);
        send_request(REQ_FREE, 12'd2730);
        send_request(REQ_ALLOC, 12'd1365);
        wait_idle();
    endtask

    task automatic test_page_count_limits();
        // Zero pages: nothing to give, every index out of range
        write_page_count(13'd0);
        send_request(REQ_ALLOC, 12'd0);
        send_request(REQ_FREE, 12'd0);
        send_request(REQ_MARK, 12'd0);
        wait_idle();
        // Saturate above the index space
        write_page_count(13'h1FFF);
        send_request(REQ_FREE, 12'd4095);
        send_request(REQ_ALLOC, 12'd0);
        wait_idle();
        // One page only
        write_page_count(13'd1);
        send_request(REQ_FREE, 12'd0);
        send_request(REQ_FREE, 12'd1);
        send_request(REQ_MARK, 12'd4095);
        send_request(REQ_ALLOC, 12'd0);
        send_request(REQ_ALLOC, 12'd0);
        wait_idle();
    endtask

    task automatic run_random_phase(logic [12:0] count, int items, bit with_gaps);
        write_page_count(count);
        gaps_enabled = with_gaps;
        burst_left   = 0;
        for (int n = 0; n < items; n++) begin
            send_request(pick_kind(), pick_index());
            pace_requests();
        end
        wait_idle();
    endtask

    task automatic test_random_mix();
        run_random_phase(13'd64, 150, 1'b1);
        run_random_phase(13'd4096, 150, 1'b1);
        run_random_phase(13'd65, 130, 1'b0);
        run_random_phase(13'd1, 60, 1'b1);
        run_random_phase(13'h1FFF, 130, 1'b1);
        run_random_phase(13'd0, 40, 1'b1);
        run_random_phase(13'd4097, 120, 1'b0);
        run_random_phase(13'd200, 150, 1'b1);
        for (int k = 0; k < 3; k++) begin
            run_random_phase(13'($urandom_range(2, 4095)), 130, 1'b1);
        end
    endtask

    initial begin
        for (int p = 0; p < PAGE_SLOTS; p++) page_used[p] = 1'b1;
        page_count = 13'd4096;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_and_corners();
        test_page_count_limits();
        test_random_mix();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_replies.size() > 0) begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, pending_replies.size());
        end
        $display("Sent %0d requests over %0d page count settings; checked %0d results",
                 request_count, setting_count, reply_count);
        $display("Seen %0d nonzero grants, %0d out-of-memory, %0d out-of-range",
                 grant_count, oom_count, range_count);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
